### hdl/npcs_pkg.sv
`timescale 1ns / 1ps

package npcs_pkg;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Component and error widths
    localparam int COMP_W = 6;
    localparam int LUMA_W = 7;
    localparam int DIFF_W = 7;
    localparam int SQ_W   = 14;
    localparam int ERR_W  = 15;
    localparam int OUT_ERR_W = 14;
    localparam int OUT_IDX_W = 8;

    // Largest error reported on the output
    localparam logic [OUT_ERR_W-1:0] ERR_SAT = '1;

    // One palette entry: color components plus derived luminance
    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        logic [LUMA_W-1:0] l;
    } pal_entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write_en;
        logic start_query;
        logic read_en;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_addr;
    } dp_status_t;

    // Luminance (4r + 5g + 2b) / 10, truncated; divide by 10 as multiply by 205 >> 11,
    // exact for sums up to 693
    function automatic logic [LUMA_W-1:0] luma(
        input logic [COMP_W-1:0] r,
        input logic [COMP_W-1:0] g,
        input logic [COMP_W-1:0] b
    );
        logic [9:0]  s;
        logic [17:0] p;
        s = {2'b00, r, 2'b00} + (10'(g) * 10'd5) + {3'b000, b, 1'b0};
        p = 18'(s) * 18'd205;
        return p[17:11];
    endfunction

    // Absolute difference of two 7-bit values
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [DIFF_W-1:0] a,
        input logic [DIFF_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### hdl/npcs_ctrl.sv
`timescale 1ns / 1ps

module npcs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  func,
    input  logic                  out_stall,
    input  npcs_pkg::dp_status_t  status,
    output logic                  in_stall,
    output logic                  out_valid,
    output npcs_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequence requests: a write is done on accept, a query runs as scan, drain, then hand off
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func == npcs_pkg::FUNC_QUERY)
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.read_en = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/npcs_dp.sv
`timescale 1ns / 1ps

module npcs_dp
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  npcs_pkg::dp_cmd_t                     cmd,
    input  logic [7:0]                            entry_index,
    input  logic [npcs_pkg::COMP_W-1:0]           red,
    input  logic [npcs_pkg::COMP_W-1:0]           green,
    input  logic [npcs_pkg::COMP_W-1:0]           blue,
    input  logic [15:0]                           pixel,
    output npcs_pkg::dp_status_t                  status,
    output logic [npcs_pkg::OUT_IDX_W-1:0]        nearest_index,
    output logic [npcs_pkg::OUT_ERR_W-1:0]        best_error
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    // Palette store and per-entry valid bits (an unwritten entry reads as zero)
    npcs_pkg::pal_entry_t       mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg, valid_next;

    npcs_pkg::pal_entry_t       wr_entry;
    logic                       wr_hit;
    logic [AW-1:0]              wr_addr;

    // Query registers
    logic [npcs_pkg::COMP_W-1:0] q_r_reg, q_g_reg, q_b_reg;
    logic [npcs_pkg::LUMA_W-1:0] q_l_reg;
    logic [npcs_pkg::COMP_W-1:0] px_r, px_g, px_b;

    // Scan and read stage
    logic [AW-1:0]              cnt_reg, cnt_next;
    npcs_pkg::pal_entry_t       rd_entry_reg;
    logic                       rd_valid_reg;
    logic [AW-1:0]              rd_idx_reg;
    logic                       cmp_en_reg, cmp_en_next;

    // Compare stage
    npcs_pkg::pal_entry_t       cur;
    logic [npcs_pkg::DIFF_W-1:0] d_r, d_g, d_b, d_l;
    logic [npcs_pkg::SQ_W-1:0]  s_r, s_g, s_b, s_l;
    logic [npcs_pkg::ERR_W-1:0] err;
    logic                       take;
    logic [npcs_pkg::ERR_W-1:0] best_err_reg, best_err_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;

    // Output register
    logic [npcs_pkg::OUT_IDX_W-1:0] nearest_index_reg;
    logic [npcs_pkg::OUT_ERR_W-1:0] best_error_reg;

    // Build the entry to store; drop writes past the end of the palette
    assign wr_entry.r = red;
    assign wr_entry.g = green;
    assign wr_entry.b = blue;
    assign wr_entry.l = npcs_pkg::luma(red, green, blue);
    assign wr_hit     = cmd.write_en && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign wr_addr    = entry_index[AW-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_hit)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.read_en)
        begin
            rd_entry_reg <= mem[cnt_reg];
        end
    end

    // Expand the RGB565 pixel to 6-bit components
    assign px_r = {pixel[15:11], 1'b0};
    assign px_g = pixel[10:5];
    assign px_b = {pixel[4:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            q_r_reg <= px_r;
            q_g_reg <= px_g;
            q_b_reg <= px_b;
            q_l_reg <= npcs_pkg::luma(px_r, px_g, px_b);
        end
    end

    // Advance the scan address one entry per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start_query)
        begin
            cnt_next = '0;
        end
        else if (cmd.read_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign status.last_addr = (cnt_reg == LAST_ADDR);
    assign cmp_en_next      = cmd.read_en;

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            rd_idx_reg   <= cnt_reg;
            rd_valid_reg <= valid_reg[cnt_reg];
        end
    end

    // Unweighted squared distance of the entry just read, over r, g, b and luminance
    assign cur = rd_valid_reg ? rd_entry_reg : '0;
    assign d_r = npcs_pkg::abs_diff({1'b0, q_r_reg}, {1'b0, cur.r});
    assign d_g = npcs_pkg::abs_diff({1'b0, q_g_reg}, {1'b0, cur.g});
    assign d_b = npcs_pkg::abs_diff({1'b0, q_b_reg}, {1'b0, cur.b});
    assign d_l = npcs_pkg::abs_diff(q_l_reg, cur.l);
    assign s_r = npcs_pkg::SQ_W'(d_r) * npcs_pkg::SQ_W'(d_r);
    assign s_g = npcs_pkg::SQ_W'(d_g) * npcs_pkg::SQ_W'(d_g);
    assign s_b = npcs_pkg::SQ_W'(d_b) * npcs_pkg::SQ_W'(d_b);
    assign s_l = npcs_pkg::SQ_W'(d_l) * npcs_pkg::SQ_W'(d_l);
    assign err = npcs_pkg::ERR_W'(16'(s_r) + 16'(s_g) + 16'(s_b) + 16'(s_l));

    // Keep the first entry with the smallest error
    assign take = cmp_en_reg && (err < best_err_reg);

    always_comb
    begin
        best_err_next = best_err_reg;
        best_idx_next = best_idx_reg;
        if (cmd.start_query)
        begin
            best_err_next = '1;
            best_idx_next = '0;
        end
        else if (take)
        begin
            best_err_next = err;
            best_idx_next = rd_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_err_reg <= best_err_next;
        best_idx_reg <= best_idx_next;
    end

    // Load the result, saturating the error to the output width
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            nearest_index_reg <= npcs_pkg::OUT_IDX_W'(best_idx_reg);
            if (best_err_reg > npcs_pkg::ERR_W'(npcs_pkg::ERR_SAT))
            begin
                best_error_reg <= npcs_pkg::ERR_SAT;
            end
            else
            begin
                best_error_reg <= best_err_reg[npcs_pkg::OUT_ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
            cmp_en_reg <= cmp_en_next;
        end
    end

    assign nearest_index = nearest_index_reg;
    assign best_error    = best_error_reg;

endmodule

### hdl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Nearest palette color search.
// Input channel (in_valid / in_stall) takes one request per accept. func = 0
// writes palette entry entry_index with red, green, blue; its luminance is
// derived on the spot. Writes past the palette size are dropped. A write
// produces no result.
// func = 1 matches the RGB565 pixel against every palette entry and returns
// nearest_index and best_error (saturated to 14 bits) on the output channel
// (out_valid / out_stall); the lowest index wins on a tie.
// A query walks the palette through one read port and one distance unit,
// one entry per cycle: the scan, a drain step and the hand-off to the output
// register follow each other, and no new request is taken until the result
// has been handed off.
// The result sits in an output register: the input side accepts new requests
// while it waits. If the receiver still stalls an earlier result when a scan
// ends, the block holds the new result internally until the register frees.
// Reset empties the output register and marks every palette entry as zero.
module nearest_palette_color_search
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  entry_index,
    input  logic [5:0]  red,
    input  logic [5:0]  green,
    input  logic [5:0]  blue,
    input  logic [15:0] pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  nearest_index,
    output logic [13:0] best_error
);

    npcs_pkg::dp_cmd_t    cmd;
    npcs_pkg::dp_status_t status;

    npcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    npcs_dp
    #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .pixel         (pixel),
        .status        (status),
        .nearest_index (nearest_index),
        .best_error    (best_error)
    );

endmodule
